// ===== rtl/lrs_pkg.sv =====
// Shared types and constants for the literal replace stream block.
`default_nettype none

package lrs_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int MAX_REPL   = 8;
   localparam int OUT_DEPTH  = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_last;
   } rsp_payload_type;

   // Per-cell control of the window row.
   typedef struct packed {
      logic at_fill;
      logic next_at_fill;
      logic write_en;
      logic shift;
   } win_ctl_type;

   // Shared control of the output row.
   typedef struct packed {
      logic load;
      logic shift;
   } out_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/lrs_win_cell.sv =====
// One byte cell of the match window: holds a byte, compares it and shifts it down.
`default_nettype none

module lrs_win_cell
   import lrs_pkg::*;
(
   input  wire logic        clock,
   input  wire win_ctl_type ctl,
   input  wire logic [7:0]  new_byte,
   input  wire logic [7:0]  nbr_byte,
   input  wire logic [7:0]  pat_byte,
   output logic      [7:0]  held_byte,
   output logic      [7:0]  cand_byte,
   output logic             match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // The candidate window places the incoming byte at the fill position.
   assign cand_byte = ctl.at_fill ? new_byte : byte_ff;
   assign match     = (cand_byte == pat_byte);
   assign held_byte = byte_ff;

   // Append at the fill position, or move one place toward the oldest end.
   always_comb begin
      priority if (ctl.write_en && ctl.at_fill) begin
         byte_in = new_byte;
      end else if (ctl.shift) begin
         byte_in = ctl.next_at_fill ? new_byte : nbr_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lrs_out_cell.sv =====
// One byte cell of the output burst row: loads a burst byte or takes its neighbor's.
`default_nettype none

module lrs_out_cell
   import lrs_pkg::*;
(
   input  wire logic        clock,
   input  wire out_ctl_type ctl,
   input  wire logic [7:0]  load_byte,
   input  wire logic [7:0]  nbr_byte,
   output logic      [7:0]  held_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // A new burst wins over the shift of the one that is draining.
   always_comb begin
      priority if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift) begin
         byte_in = nbr_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/literal_replace_stream_core.sv =====
// Top level of the streaming literal find-and-replace block.
`default_nettype none

// Streaming literal find-and-replace. Bytes enter a row of MAX_PATTERN window
// cells; when the window is full and equals the pattern, the replacement bytes
// are emitted and the window empties, otherwise the oldest byte leaves. A
// request marked last flushes the window, and if it yields nothing a single
// end marker (byte_present low) closes the text. Each request loads its whole
// burst of results at once into an eight-cell output row, which drains one
// result per cycle while rsp_ready is high. A new request is taken as soon as
// that row is empty or its final result leaves in the same cycle, so plain text
// flows one request per cycle while rsp_ready is high; a long replacement or
// final flush of up to eight results holds the input until its last result
// leaves. Configuration is to be written through the csr port while idle,
// which the block does not enforce. A pattern length write empties the window.
module literal_replace_stream_core
   import lrs_pkg::*;
#(
   parameter int MAX_PATTERN = 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] MAX_PAT_LEN  = LEN_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0] MAX_REPL_LEN = LEN_W'(MAX_REPL);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [LEN_W-1:0]      pat_len_ff;
   logic [CSR_DATA_W-1:0] repl_ff;
   logic [LEN_W-1:0]      repl_len_ff;

   // Window and output state.
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [LEN_W-1:0]  cnt_ff;
   logic [LEN_W-1:0]  cnt_in;
   logic              last_ff;
   logic              last_in;
   logic              present_ff;
   logic              present_in;

   logic [LEN_W-1:0]  plen;
   logic [LEN_W-1:0]  rlen;
   logic [FILL_W-1:0] fill_eff;
   logic [LEN_W-1:0]  fill_ext;
   logic              pass_thru;
   logic              full;
   logic              matched;
   logic              req_take;
   logic              rsp_take;
   logic              sel_repl;
   logic              is_marker;
   logic [LEN_W-1:0]  burst_cnt;
   logic [LEN_W-1:0]  raw_cnt;

   logic [7:0]            win_held [MAX_PATTERN];
   logic [7:0]            win_cand [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] win_match;
   logic [MAX_PATTERN-1:0] win_ok;
   win_ctl_type           win_ctl  [MAX_PATTERN];
   logic [7:0]            burst    [OUT_DEPTH];
   logic [7:0]            out_held [OUT_DEPTH];
   out_ctl_type           out_ctl;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         pat_len_ff  <= '0;
         repl_ff     <= '0;
         repl_len_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      pattern_ff  <= csr_wdata;
            CSR_PATTERN_LENGTH:     pat_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  repl_ff     <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: repl_len_ff <= csr_wdata[LEN_W-1:0];
            default:                pattern_ff  <= pattern_ff;
         endcase
      end
   end

   // Lengths saturate at the storage the block has.
   assign plen      = (pat_len_ff > MAX_PAT_LEN) ? MAX_PAT_LEN : pat_len_ff;
   assign rlen      = (repl_len_ff > MAX_REPL_LEN) ? MAX_REPL_LEN : repl_len_ff;
   assign pass_thru = (plen == '0);
   assign fill_eff  = (LEN_W'(fill_ff) >= plen) ? '0 : fill_ff;
   assign fill_ext  = LEN_W'(fill_eff);
   assign full      = ((fill_ext + LEN_W'(1)) == plen);

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == LEN_W'(1)) && rsp_ready);
   assign req_take  = req_valid && req_ready;

   // Window row: each cell hands its byte to the cell below on a shift.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_win
      logic [7:0] nbr;
      if (k + 1 < MAX_PATTERN) begin : g_nbr
         assign nbr = win_held[k+1];
      end else begin : g_end
         assign nbr = '0;
      end

      assign win_ctl[k].at_fill      = (fill_eff == FILL_W'(k));
      assign win_ctl[k].next_at_fill = (fill_eff == FILL_W'(k + 1));
      assign win_ctl[k].write_en     = req_take && !pass_thru && !full;
      assign win_ctl[k].shift        = req_take && !pass_thru && full && !matched;
      assign win_ok[k] = win_match[k] || (LEN_W'(k) >= plen);

      lrs_win_cell u_cell (
         .clock     (clock),
         .ctl       (win_ctl[k]),
         .new_byte  (req_payload.in_byte),
         .nbr_byte  (nbr),
         .pat_byte  (pattern_ff[8*k +: 8]),
         .held_byte (win_held[k]),
         .cand_byte (win_cand[k]),
         .match     (win_match[k])
      );
   end

   assign matched = &win_ok;

   // Number of results this request produces and where they come from.
   always_comb begin
      sel_repl = 1'b0;
      priority if (pass_thru) begin
         raw_cnt = LEN_W'(1);
      end else if (full && matched) begin
         raw_cnt  = rlen;
         sel_repl = 1'b1;
      end else if (full) begin
         raw_cnt = req_payload.in_last ? plen : LEN_W'(1);
      end else begin
         raw_cnt = req_payload.in_last ? (fill_ext + LEN_W'(1)) : '0;
      end
   end

   assign is_marker = req_payload.in_last && (raw_cnt == '0);
   assign burst_cnt = is_marker ? LEN_W'(1) : raw_cnt;

   // Window fill after the request.
   always_comb begin
      priority if (csr_we && (csr_index == CSR_PATTERN_LENGTH)) begin
         fill_in = '0;
      end else if (!req_take || pass_thru) begin
         fill_in = fill_ff;
      end else if (req_payload.in_last || (full && matched)) begin
         fill_in = '0;
      end else if (full) begin
         fill_in = FILL_W'(plen - LEN_W'(1));
      end else begin
         fill_in = fill_eff + FILL_W'(1);
      end
   end

   // Burst contents, lowest cell leaves first.
   for (genvar k = 0; k < OUT_DEPTH; k++) begin : g_burst
      logic [7:0] text_byte;
      if (k < MAX_PATTERN) begin : g_txt
         assign text_byte = win_cand[k];
      end else begin : g_none
         assign text_byte = '0;
      end
      assign burst[k] = sel_repl ? repl_ff[8*k +: 8] : text_byte;
   end

   // Output row.
   assign out_ctl.load  = req_take;
   assign out_ctl.shift = rsp_take;

   for (genvar k = 0; k < OUT_DEPTH; k++) begin : g_out
      logic [7:0] nbr;
      if (k + 1 < OUT_DEPTH) begin : g_nbr
         assign nbr = out_held[k+1];
      end else begin : g_end
         assign nbr = '0;
      end

      lrs_out_cell u_cell (
         .clock     (clock),
         .ctl       (out_ctl),
         .load_byte (burst[k]),
         .nbr_byte  (nbr),
         .held_byte (out_held[k])
      );
   end

   // Burst bookkeeping.
   always_comb begin
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      present_in = present_ff;
      priority if (req_take) begin
         cnt_in     = burst_cnt;
         last_in    = req_payload.in_last;
         present_in = !is_marker;
      end else if (rsp_take) begin
         cnt_in = cnt_ff - LEN_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         cnt_ff     <= '0;
         last_ff    <= 1'b0;
         present_ff <= 1'b1;
      end else begin
         fill_ff    <= fill_in;
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
         present_ff <= present_in;
      end
   end

   assign rsp_payload.out_byte     = present_ff ? out_held[0] : '0;
   assign rsp_payload.byte_present = present_ff;
   assign rsp_payload.out_last     = last_ff && (cnt_ff == LEN_W'(1));

   // The window never holds a full pattern between requests.
   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      (LEN_W'(fill_ff) < plen) || (fill_ff == '0))
      else $error("window fill reached the pattern length");

   // A burst never exceeds the output row.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LEN_W'(OUT_DEPTH))
      else $error("output burst count exceeds the row depth");

   // An accepted request loads exactly its burst count.
   a_burst_load: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (cnt_ff == $past(burst_cnt)))
      else $error("burst count not loaded from the accepted request");

   // An end marker is always the single, final result of the text.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !present_ff) |-> (last_ff && (cnt_ff == LEN_W'(1))))
      else $error("end marker is not the final result");

endmodule

`default_nettype wire
